[src/scc_pkg.sv]
// Shared types and constants for the selectable CRC / checksum block.
package scc_pkg;

    localparam int unsigned CHECK_W  = 32;
    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned CFG_IDX_W = 2;

    typedef enum logic [1:0] {
        MODE_SUM  = 2'd0,
        MODE_MSB  = 2'd1,
        MODE_REFL = 2'd2,
        MODE_ZERO = 2'd3
    } check_mode_t;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_MODE     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_MSB_POLY = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_REFL_POLY = 2'd2;

    localparam logic [CHECK_W-1:0] MSB_POLY_RESET  = 32'h04C1_1DB7;
    localparam logic [CHECK_W-1:0] REFL_POLY_RESET = 32'h82F6_3B78;
    localparam logic [CHECK_W-1:0] REFL_INIT       = 32'hFFFF_FFFF;

    typedef struct packed {
        check_mode_t        mode;
        logic [CHECK_W-1:0] msb_poly;
        logic [CHECK_W-1:0] refl_poly;
    } scc_cfg_t;

endpackage

[src/selectable_crc_checksum.sv]
// out_valid rises once the staged last byte is folded into the check; between the last
// byte's transaction and its result lie the byte register and the result register.
// Throughput: one byte per cycle; the byte register feeds an unrolled
// eight-bit fold that closes on the running check register each cycle.
// The input stalls only when a finished result is still waiting for out_ready.
// Reset (rst_n, asynchronous) sets mode 0, default polynomials, check to zero.
module selectable_crc_checksum
    import scc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CHECK_W-1:0]   cfg_data,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [BYTE_W-1:0]    data_byte,
    input  logic                 first_byte,
    input  logic                 last_byte,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [CHECK_W-1:0]   check_value
);

    scc_cfg_t           cfg;
    logic               stage_valid_reg;
    logic [BYTE_W-1:0]  stage_data_reg;
    logic               stage_first_reg;
    logic               stage_last_reg;
    logic [CHECK_W-1:0] running_check_reg;
    logic [CHECK_W-1:0] running_check_next;
    logic               out_valid_reg;
    logic [CHECK_W-1:0] check_value_reg;
    logic               stage_go;

    scc_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    scc_fold u_fold (
        .cfg      (cfg),
        .acc      (running_check_reg),
        .data     (stage_data_reg),
        .first    (stage_first_reg),
        .acc_next (running_check_next)
    );

    // A byte without a last mark always moves on; a last byte waits for the
    // result register to be free or emptied in this cycle.
    assign stage_go = stage_valid_reg
                      && !(stage_last_reg && out_valid_reg && !out_ready);
    assign in_ready = !stage_valid_reg || stage_go;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg   <= 1'b0;
            running_check_reg <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
                stage_valid_reg <= 1'b1;
            else if (stage_go)
                stage_valid_reg <= 1'b0;

            if (stage_go)
                running_check_reg <= running_check_next;

            if (stage_go && stage_last_reg)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            stage_data_reg  <= data_byte;
            stage_first_reg <= first_byte;
            stage_last_reg  <= last_byte;
        end
        if (stage_go && stage_last_reg)
            check_value_reg <= running_check_next;
    end

    assign out_valid   = out_valid_reg;
    assign check_value = check_value_reg;

endmodule

[src/scc_cfg.sv]
// Configuration register file: check mode and the two CRC polynomials.
module scc_cfg
    import scc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CHECK_W-1:0]   cfg_data,
    output scc_cfg_t             cfg
);

    check_mode_t        mode_reg;
    logic [CHECK_W-1:0] msb_poly_reg;
    logic [CHECK_W-1:0] refl_poly_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_SUM;
            msb_poly_reg  <= MSB_POLY_RESET;
            refl_poly_reg <= REFL_POLY_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_IDX_MODE:      mode_reg      <= check_mode_t'(cfg_data[1:0]);
                CFG_IDX_MSB_POLY:  msb_poly_reg  <= cfg_data;
                CFG_IDX_REFL_POLY: refl_poly_reg <= cfg_data;
                default:           ;
            endcase
        end
    end

    assign cfg.mode      = mode_reg;
    assign cfg.msb_poly  = msb_poly_reg;
    assign cfg.refl_poly = refl_poly_reg;

endmodule

[src/scc_fold.sv]
// Combinational fold of one byte into the running check for the selected mode.
module scc_fold
    import scc_pkg::*;
(
    input  scc_cfg_t           cfg,
    input  logic [CHECK_W-1:0] acc,
    input  logic [BYTE_W-1:0]  data,
    input  logic               first,
    output logic [CHECK_W-1:0] acc_next
);

    always_comb
    begin
        logic [CHECK_W-1:0] msb_crc;
        logic [CHECK_W-1:0] refl_crc;

        // MSB-first CRC, eight shift steps unrolled.
        msb_crc = (first ? '0 : acc) ^ {data, {(CHECK_W-BYTE_W){1'b0}}};
        for (int k = 0; k < BYTE_W; k++)
        begin
            if (msb_crc[CHECK_W-1])
                msb_crc = {msb_crc[CHECK_W-2:0], 1'b0} ^ cfg.msb_poly;
            else
                msb_crc = {msb_crc[CHECK_W-2:0], 1'b0};
        end

        // Reflected CRC, shifting toward the LSB.
        refl_crc = (first ? REFL_INIT : acc) ^ {{(CHECK_W-BYTE_W){1'b0}}, data};
        for (int k = 0; k < BYTE_W; k++)
        begin
            if (refl_crc[0])
                refl_crc = {1'b0, refl_crc[CHECK_W-1:1]} ^ cfg.refl_poly;
            else
                refl_crc = {1'b0, refl_crc[CHECK_W-1:1]};
        end

        unique case (cfg.mode)
            MODE_SUM:  acc_next = (first ? '0 : acc) + {{(CHECK_W-BYTE_W){1'b0}}, data};
            MODE_MSB:  acc_next = msb_crc;
            MODE_REFL: acc_next = refl_crc;
            MODE_ZERO: acc_next = '0;
            default:   acc_next = '0;
        endcase
    end

endmodule

[bench/tb.sv]
// Self-checking testbench for the selectable CRC / byte-sum message checker.
`timescale 1ns / 100ps

module tb;
    import scc_pkg::*;

    localparam int unsigned NUM_PHASES      = 11;
    localparam int unsigned BYTES_PER_PHASE = 100;
    localparam int unsigned DRAIN_CYCLES    = 8;
    localparam int unsigned STALL_LIMIT     = 1000;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNUSED = 2'd3;

    typedef enum logic {
        ROW_CFG,
        ROW_BYTE
    } row_kind_t;

    typedef struct {
        row_kind_t              kind;
        logic [CFG_IDX_W-1:0]   index;
        logic [CHECK_W-1:0]     data;
        logic [BYTE_W-1:0]      value;
        logic                   first;
        logic                   last;
        bit                     known;
        logic [CHECK_W-1:0]     known_check;
    } stim_row_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CHECK_W-1:0]   cfg_data = '0;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    logic [BYTE_W-1:0]    data_byte = '0;
    logic                 first_byte = 1'b0;
    logic                 last_byte = 1'b0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic [CHECK_W-1:0]   check_value;

    scc_cfg_t             expected_cfg;
    logic [CHECK_W-1:0]   predicted_check;
    logic [CHECK_W-1:0]   pending_checks[$];
    stim_row_t            stimulus_table[$];

    bit                   no_idling = 1'b0;
    int                   stall_left = 0;
    int                   idle_cycles = 0;
    int                   fail_count = 0;
    int                   bytes_sent = 0;
    int                   results_checked = 0;
    int                   register_writes = 0;

    selectable_crc_checksum i_dut (
        .clk,
        .rst_n,
        .cfg_valid,
        .cfg_ready,
        .cfg_index,
        .cfg_data,
        .in_valid,
        .in_ready,
        .data_byte,
        .first_byte,
        .last_byte,
        .out_valid,
        .out_ready,
        .check_value
    );

    always #6 clk = ~clk;

    // Folds one byte into the running check under the current register settings.
    function automatic logic [CHECK_W-1:0] next_check(input logic [CHECK_W-1:0] acc_in,
                                                      input logic [BYTE_W-1:0] value,
                                                      input logic first);
        logic [CHECK_W-1:0] acc;
        acc = acc_in;
        case (expected_cfg.mode)
            MODE_SUM:
            begin
                if (first)
                    acc = '0;
                acc = acc + {24'd0, value};
            end
            MODE_MSB:
            begin
                if (first)
                    acc = '0;
                acc = acc ^ {value, 24'd0};
                for (int k = 0; k < 8; k++)
                    acc = acc[31] ? ((acc << 1) ^ expected_cfg.msb_poly) : (acc << 1);
            end
            MODE_REFL:
            begin
                if (first)
                    acc = REFL_INIT;
                acc = acc ^ {24'd0, value};
                for (int k = 0; k < 8; k++)
                    acc = acc[0] ? ((acc >> 1) ^ expected_cfg.refl_poly) : (acc >> 1);
            end
            default:
                acc = '0;
        endcase
        return acc;
    endfunction

    function automatic logic [CHECK_W-1:0] pick_poly(input logic [CHECK_W-1:0] dflt);
        case ($urandom_range(0, 4))
            0: return '0;
            1: return '1;
            2: return dflt;
            default: return $urandom();
        endcase
    endfunction

    task automatic add_cfg(input logic [CFG_IDX_W-1:0] index, input logic [CHECK_W-1:0] data);
        stim_row_t row;
        row.kind        = ROW_CFG;
        row.index       = index;
        row.data        = data;
        row.value       = '0;
        row.first       = 1'b0;
        row.last        = 1'b0;
        row.known       = 1'b0;
        row.known_check = '0;
        stimulus_table.push_back(row);
    endtask

    task automatic add_byte(input logic [BYTE_W-1:0] value, input logic first, input logic last,
                            input bit known, input logic [CHECK_W-1:0] known_check);
        stim_row_t row;
        row.kind        = ROW_BYTE;
        row.index       = '0;
        row.data        = '0;
        row.value       = value;
        row.first       = first;
        row.last        = last;
        row.known       = known;
        row.known_check = known_check;
        stimulus_table.push_back(row);
    endtask

    // Valid stays high after a transaction; the next call either reloads it or lowers it.
    task automatic send_byte(input logic [BYTE_W-1:0] value, input logic first, input logic last,
                             input bit known, input logic [CHECK_W-1:0] known_check);
        int gap;
        gap = 0;
        if (!no_idling && $urandom_range(0, 5) == 0)
            gap = $urandom_range(1, 4);
        cfg_valid <= 1'b0;
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        data_byte  <= value;
        first_byte <= first;
        last_byte  <= last;
        do @(posedge clk); while (!in_ready);
        predicted_check = next_check(predicted_check, value, first);
        bytes_sent++;
        if (last)
            pending_checks.push_back(known ? known_check : predicted_check);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] index, input logic [CHECK_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        register_writes++;
        case (index)
            CFG_IDX_MODE:      expected_cfg.mode = check_mode_t'(data[1:0]);
            CFG_IDX_MSB_POLY:  expected_cfg.msb_poly = data;
            CFG_IDX_REFL_POLY: expected_cfg.refl_poly = data;
            default: ;
        endcase
    endtask

    // Bytes without a last mark leave no result, so wait out the pipeline too.
    task automatic drain_pipeline();
        in_valid  <= 1'b0;
        cfg_valid <= 1'b0;
        while (pending_checks.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_ready  <= 1'b0;
            stall_left <= 0;
        end
        else if (stall_left != 0)
        begin
            out_ready  <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else if (!no_idling && $urandom_range(0, 4) == 0)
        begin
            out_ready  <= 1'b0;
            stall_left <= $urandom_range(0, 3);
        end
        else
        begin
            out_ready <= 1'b1;
        end

        if (rst_n && out_valid && out_ready)
        begin
            if (pending_checks.size() == 0)
            begin
                $error("check_value: expected nothing, actual %08h", check_value);
                fail_count++;
            end
            else
            begin
                if (check_value !== pending_checks[0])
                begin
                    $error("check_value: expected %08h, actual %08h",
                           pending_checks[0], check_value);
                    fail_count++;
                end
                void'(pending_checks.pop_front());
                results_checked++;
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (cfg_valid && cfg_ready)
            || (out_valid && out_ready))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("selectable_crc_checksum regression: fail");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        check_mode_t        mode;
        logic [CHECK_W-1:0] word;
        int                 phase_bytes;
        int                 len;

        expected_cfg.mode      = MODE_SUM;
        expected_cfg.msb_poly  = MSB_POLY_RESET;
        expected_cfg.refl_poly = REFL_POLY_RESET;
        predicted_check        = '0;

        // Without a first mark the byte continues from the check as it stands.
        add_byte(8'hA5, 1'b0, 1'b1, 1'b1, 32'h0000_00A5);
        add_byte(8'hFF, 1'b1, 1'b1, 1'b1, 32'h0000_00FF);
        add_byte(8'hFF, 1'b1, 1'b0, 1'b0, '0);
        add_byte(8'hFF, 1'b0, 1'b0, 1'b0, '0);
        add_byte(8'hFF, 1'b0, 1'b1, 1'b1, 32'h0000_02FD);
        add_byte(8'h00, 1'b0, 1'b1, 1'b1, 32'h0000_02FD);
        add_cfg(CFG_IDX_MODE, 32'(MODE_MSB));
        add_byte(8'h00, 1'b1, 1'b1, 1'b1, '0);
        add_byte(8'hFF, 1'b1, 1'b0, 1'b0, '0);
        add_byte(8'h00, 1'b0, 1'b0, 1'b0, '0);
        add_byte(8'h80, 1'b0, 1'b1, 1'b0, '0);
        // Only the low two bits of a mode write count.
        add_cfg(CFG_IDX_MODE, {30'h3FFF_FFFF, MODE_REFL});
        // The standard check string; this mode skips the final inversion.
        for (int i = 0; i < 9; i++)
            add_byte(8'h31 + 8'(i), i == 0, i == 8, 1'b1, 32'h1CF9_6D7C);
        add_cfg(CFG_IDX_MODE, 32'(MODE_ZERO));
        add_byte(8'h5A, 1'b1, 1'b1, 1'b1, '0);
        // A mode change in the middle of a message.
        add_cfg(CFG_IDX_MODE, 32'(MODE_SUM));
        add_byte(8'h12, 1'b1, 1'b0, 1'b0, '0);
        add_cfg(CFG_IDX_MODE, 32'(MODE_REFL));
        add_byte(8'h34, 1'b0, 1'b1, 1'b0, '0);
        add_cfg(CFG_IDX_MSB_POLY, '0);
        add_cfg(CFG_IDX_MODE, 32'(MODE_MSB));
        add_byte(8'hFF, 1'b1, 1'b1, 1'b1, '0);
        add_cfg(CFG_IDX_UNUSED, 32'hDEAD_BEEF);
        add_cfg(CFG_IDX_REFL_POLY, '1);
        add_cfg(CFG_IDX_MODE, 32'(MODE_REFL));
        add_byte(8'h00, 1'b1, 1'b1, 1'b0, '0);

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        foreach (stimulus_table[i])
        begin
            if (stimulus_table[i].kind == ROW_CFG)
            begin
                drain_pipeline();
                cfg_write(stimulus_table[i].index, stimulus_table[i].data);
            end
            else
            begin
                send_byte(stimulus_table[i].value, stimulus_table[i].first,
                          stimulus_table[i].last, stimulus_table[i].known,
                          stimulus_table[i].known_check);
            end
        end

        for (int phase = 0; phase < NUM_PHASES; phase++)
        begin
            drain_pipeline();
            no_idling = (phase == 4) || (phase == NUM_PHASES - 1);
            cfg_write(CFG_IDX_MSB_POLY, pick_poly(MSB_POLY_RESET));
            cfg_write(CFG_IDX_REFL_POLY, pick_poly(REFL_POLY_RESET));
            if ($urandom_range(0, 3) == 0)
                cfg_write(CFG_IDX_UNUSED, $urandom());
            mode = (phase < 8) ? check_mode_t'(phase % 4) : check_mode_t'($urandom_range(0, 3));
            word = $urandom();
            word[1:0] = mode;
            cfg_write(CFG_IDX_MODE, word);

            phase_bytes = 0;
            while (phase_bytes < BYTES_PER_PHASE)
            begin
                // Hold the stream until every result is back, then switch modes,
                // often with a message still open.
                if ((phase == 2 && phase_bytes >= BYTES_PER_PHASE / 2
                     && phase_bytes < BYTES_PER_PHASE / 2 + 8)
                    || $urandom_range(0, 29) == 0)
                begin
                    drain_pipeline();
                    word = $urandom();
                    cfg_write(CFG_IDX_MODE, word);
                end
                if ($urandom_range(0, 9) == 0)
                begin
                    send_byte(8'($urandom()), 1'($urandom()), 1'($urandom()), 1'b0, '0);
                    phase_bytes++;
                end
                else
                begin
                    len = ($urandom_range(0, 3) == 0) ? $urandom_range(9, 32)
                                                     : $urandom_range(1, 8);
                    for (int i = 0; i < len; i++)
                        send_byte(8'($urandom()), i == 0, i == len - 1, 1'b0, '0);
                    phase_bytes += len;
                end
            end
        end

        drain_pipeline();
        $display("Sent %0d bytes under %0d register writes in all four modes,",
                 bytes_sent, register_writes);
        $display("including extreme polynomials; %0d check values compared.", results_checked);
        if (fail_count == 0)
            $display("selectable_crc_checksum regression: pass");
        else
            $display("selectable_crc_checksum regression: fail");
        $finish;
    end

endmodule
